/* design/bba_pkg.sv */
// Package for the buddy block allocator: register defaults, codes and state type.
// Used by buddy_block_allocator_unit and its testbench; depends on nothing else.
`default_nettype none
package bba_pkg;

  // Defaults for the module parameters
  localparam int TREE_LEVELS_DEF = 11;
  localparam int ADDR_BITS_DEF   = 40;
  localparam int ORD_W           = 6;

  // Register reset values
  localparam logic [ORD_W-1:0] MIN_ORDER_RST = 6'd6;
  localparam logic [ORD_W-1:0] MAX_ORDER_RST = 6'd16;

  // Configuration register indexes
  localparam logic [1:0] REG_DEV_MIN  = 2'd0;
  localparam logic [1:0] REG_DEV_MAX  = 2'd1;
  localparam logic [1:0] REG_HOST_MIN = 2'd2;
  localparam logic [1:0] REG_HOST_MAX = 2'd3;

  // Request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOMEM    = 2'd1;
  localparam logic [1:0] ST_OVERSIZE = 2'd2;

  // Sequencer states, one-hot
  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_PREP  = 13'b0000000000010,
    S_CHK   = 13'b0000000000100,
    S_SRD   = 13'b0000000001000,
    S_SCHK  = 13'b0000000010000,
    S_ACLR  = 13'b0000000100000,
    S_SPLIT = 13'b0000001000000,
    S_WRD   = 13'b0000010000000,
    S_WCHK  = 13'b0000100000000,
    S_MRD   = 13'b0001000000000,
    S_MCHK  = 13'b0010000000000,
    S_MSET  = 13'b0100000000000,
    S_RESP  = 13'b1000000000000
  } state_t;

  // Free-count update kinds
  typedef enum logic [1:0] {
    CNT_NONE = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2
  } cnt_op_t;

endpackage
`default_nettype wire

/* design/bba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used by buddy_block_allocator_unit for the node free bits.
`default_nettype none
module bba_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* design/buddy_block_allocator_unit.sv */
// Buddy block allocator top level, two pools; node free bits in one one-read one-write RAM.
// Early errors go PREP, CHK, RESP; an alloc scans a level, clears the free node, splits down;
// a free walks up to the root, then merges with free buddies and sets the node, or stops
// when a free ancestor rejects it. One item at a time: the next is taken the cycle after its
// result is registered at the earliest; a result waits while out_tready holds the last one.
// Sync reset (rst_n) clears both pools in the RAM first, and each register write its own pool.
`default_nettype none
module buddy_block_allocator_unit #(
  parameter int TREE_LEVELS = bba_pkg::TREE_LEVELS_DEF,
  parameter int ADDR_BITS   = bba_pkg::ADDR_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // in_tdata: request_size, block_offset, zero pad
  input  wire logic                                      in_tvalid,
  output logic                                           in_tready,
  input  wire logic [((2*ADDR_BITS+1+7)/8)*8-1:0]        in_tdata,
  // in_tuser: req_type, pool_select
  input  wire logic [1:0]                                in_tuser,
  // out_tdata: block_address, block_order, status, zero pad
  output logic                                           out_tvalid,
  input  wire logic                                      out_tready,
  output logic      [((ADDR_BITS+bba_pkg::ORD_W+2+7)/8)*8-1:0] out_tdata,
  input  wire logic                                      cfg_we,
  input  wire logic [1:0]                                cfg_index,
  input  wire logic [bba_pkg::ORD_W-1:0]                 cfg_wdata
);

  localparam int TL    = TREE_LEVELS;
  localparam int LW    = (TL > 1) ? $clog2(TL) : 1;
  localparam int SW    = ADDR_BITS + 1;
  localparam int OW    = bba_pkg::ORD_W;
  localparam int OUT_W = ((ADDR_BITS+OW+2+7)/8)*8;
  localparam int MA    = TL + 1;

  // ---------------- configuration registers ----------------
  logic [OW-1:0] dev_min_r, dev_max_r, host_min_r, host_max_r;
  logic [1:0]    clr_mask_r;
  logic [MA-1:0] clr_cnt_r;
  logic          clr_busy;
  logic [1:0]    cfg_pool_hit;

  assign clr_busy = |clr_mask_r;

  always_comb begin
    cfg_pool_hit = 2'b00;
    if (cfg_we) begin
      case (cfg_index)
        bba_pkg::REG_DEV_MIN, bba_pkg::REG_DEV_MAX:   cfg_pool_hit = 2'b01;
        bba_pkg::REG_HOST_MIN, bba_pkg::REG_HOST_MAX: cfg_pool_hit = 2'b10;
        default:                                      cfg_pool_hit = 2'b00;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_min_r  <= bba_pkg::MIN_ORDER_RST;
      dev_max_r  <= bba_pkg::MAX_ORDER_RST;
      host_min_r <= bba_pkg::MIN_ORDER_RST;
      host_max_r <= bba_pkg::MAX_ORDER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bba_pkg::REG_DEV_MIN:  dev_min_r  <= cfg_wdata;
        bba_pkg::REG_DEV_MAX:  dev_max_r  <= cfg_wdata;
        bba_pkg::REG_HOST_MIN: host_min_r <= cfg_wdata;
        bba_pkg::REG_HOST_MAX: host_max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clearing pass: sweep the RAM, root of each marked pool set free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_mask_r <= 2'b11;
      clr_cnt_r  <= '0;
    end else if (|cfg_pool_hit) begin
      clr_mask_r <= clr_mask_r | cfg_pool_hit;
      clr_cnt_r  <= '0;
    end else if (clr_busy) begin
      if (&clr_cnt_r) begin
        clr_mask_r <= 2'b00;
        clr_cnt_r  <= '0;
      end else begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  // ---------------- request registers ----------------
  bba_pkg::state_t state_r, state_nxt;
  logic             req_r, pool_r;
  logic [SW-1:0]    size_r;
  logic [ADDR_BITS-1:0] off_r;
  logic [OW-1:0]    ord_r, mx_r;
  logic [LW-1:0]    tgt_r, lvl_r, lvl_nxt;
  logic             over_r;
  logic [TL-1:0]    node_r, node_nxt, walk_r, walk_nxt;
  logic [ADDR_BITS-1:0] res_addr_r, res_addr_nxt;
  logic [OW-1:0]    res_ord_r, res_ord_nxt;
  logic [1:0]       res_stat_r, res_stat_nxt;
  logic             out_tvalid_r;
  logic [OUT_W-1:0] out_tdata_r;
  logic             out_free;
  logic             in_acc;

  assign out_free  = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == bba_pkg::S_IDLE) && !clr_busy;
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r  <= in_tuser[0];
      pool_r <= in_tuser[1];
      size_r <= in_tdata[SW-1:0];
      off_r  <= in_tdata[SW+ADDR_BITS-1:SW];
    end
  end

  // ---------------- order computation (PREP) ----------------
  logic [OW-1:0] mx_sel, mn_sel, mx_e, mn_e, diff_e;
  logic [OW:0]   clog;
  logic [SW-1:0] size_m1;
  logic [OW-1:0] ord_c, ord_e;

  always_comb begin
    mx_sel = pool_r ? host_max_r : dev_max_r;
    mn_sel = pool_r ? host_min_r : dev_min_r;
    mx_e   = (mx_sel > OW'(ADDR_BITS)) ? OW'(ADDR_BITS) : mx_sel;
    mn_e   = (mn_sel > mx_e) ? mx_e : mn_sel;
    diff_e = mx_e - mn_e;
    if (diff_e > OW'(TL - 1)) begin
      mn_e = mx_e - OW'(TL - 1);
    end
    // ceiling log2: one past the top set bit of size-1
    size_m1 = size_r - 1'b1;
    clog    = '0;
    if (size_r > SW'(1)) begin
      for (int b = 0; b < SW; b++) begin
        if (size_m1[b]) clog = (OW+1)'(b + 1);
      end
    end
    ord_c = (clog > (OW+1)'(63)) ? OW'(63) : clog[OW-1:0];
    ord_e = (ord_c < mn_e) ? mn_e : ord_c;
  end

  always_ff @(posedge clk) begin
    if (state_r == bba_pkg::S_PREP) begin
      ord_r  <= ord_e;
      mx_r   <= mx_e;
      over_r <= ord_e > mx_e;
      tgt_r  <= LW'(mx_e - ord_e);
    end
  end

  // ---------------- free counts per pool and level ----------------
  logic [TL-1:0]     cnt_r [2][TL];
  bba_pkg::cnt_op_t  cnt_op;
  logic [LW-1:0]     cnt_lvl;

  always_ff @(posedge clk) begin
    for (int p = 0; p < 2; p++) begin
      if (!rst_n || cfg_pool_hit[p]) begin
        for (int l = 0; l < TL; l++) begin
          cnt_r[p][l] <= (l == 0) ? TL'(1) : '0;
        end
      end else if (pool_r == p[0]) begin
        case (cnt_op)
          bba_pkg::CNT_INC: cnt_r[p][cnt_lvl] <= cnt_r[p][cnt_lvl] + 1'b1;
          bba_pkg::CNT_DEC: cnt_r[p][cnt_lvl] <= cnt_r[p][cnt_lvl] - 1'b1;
          default: ;
        endcase
      end
    end
  end

  // Highest nonempty level not below the target order
  logic [LW-1:0] hit_lvl;
  logic          hit_any;

  always_comb begin
    hit_lvl = '0;
    hit_any = 1'b0;
    for (int l = 0; l < TL; l++) begin
      if ((LW'(l) <= tgt_r) && (cnt_r[pool_r][l] != '0)) begin
        hit_lvl = LW'(l);
        hit_any = 1'b1;
      end
    end
  end

  // Free checks: range, alignment, node index
  logic [ADDR_BITS-1:0] off_sh;
  logic [SW-1:0]        align_mask;
  logic                 free_bad;
  logic [TL-1:0]        free_node;

  always_comb begin
    off_sh     = off_r >> ord_r;
    align_mask = (SW'(1) << ord_r) - 1'b1;
    free_bad   = ((off_r >> mx_r) != '0) || ((SW'(off_r) & align_mask) != '0);
    free_node  = (TL'(1) << tgt_r) | TL'(off_sh);
  end

  // ---------------- node RAM ----------------
  logic          mem_we, mem_wdata, mem_rdata;
  logic [MA-1:0] mem_waddr, mem_raddr;
  logic          seq_we, seq_wdata;
  logic [TL-1:0] seq_waddr, seq_raddr;

  assign mem_we    = clr_busy ? clr_mask_r[clr_cnt_r[MA-1]] : seq_we;
  assign mem_waddr = clr_busy ? clr_cnt_r : {pool_r, seq_waddr};
  assign mem_wdata = clr_busy ? (clr_cnt_r[TL-1:0] == TL'(1)) : seq_wdata;
  assign mem_raddr = {pool_r, seq_raddr};

  bba_ram #(
    .WIDTH(1),
    .DEPTH(1 << MA)
  ) u_nodes (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // ---------------- sequencer ----------------
  logic [LW-1:0] lvl_up;
  assign lvl_up = lvl_r + 1'b1;

  always_comb begin
    state_nxt    = state_r;
    lvl_nxt      = lvl_r;
    node_nxt     = node_r;
    walk_nxt     = walk_r;
    res_addr_nxt = res_addr_r;
    res_ord_nxt  = res_ord_r;
    res_stat_nxt = res_stat_r;
    seq_we       = 1'b0;
    seq_wdata    = 1'b0;
    seq_waddr    = node_r;
    seq_raddr    = node_r;
    cnt_op       = bba_pkg::CNT_NONE;
    cnt_lvl      = lvl_r;
    case (state_r)
      bba_pkg::S_IDLE: begin
        if (in_acc) state_nxt = bba_pkg::S_PREP;
      end
      bba_pkg::S_PREP: state_nxt = bba_pkg::S_CHK;
      bba_pkg::S_CHK: begin
        res_addr_nxt = '0;
        res_ord_nxt  = '0;
        res_stat_nxt = bba_pkg::ST_OVERSIZE;
        if (over_r) begin
          state_nxt = bba_pkg::S_RESP;
        end else if (req_r == bba_pkg::REQ_ALLOC) begin
          if (!hit_any) begin
            res_stat_nxt = bba_pkg::ST_NOMEM;
            state_nxt    = bba_pkg::S_RESP;
          end else begin
            lvl_nxt   = hit_lvl;
            node_nxt  = TL'(1) << hit_lvl;
            state_nxt = bba_pkg::S_SRD;
          end
        end else if (free_bad) begin
          state_nxt = bba_pkg::S_RESP;
        end else begin
          node_nxt  = free_node;
          walk_nxt  = free_node;
          state_nxt = bba_pkg::S_WRD;
        end
      end
      // scan the level for its lowest free node
      bba_pkg::S_SRD: begin
        seq_raddr = node_r;
        state_nxt = bba_pkg::S_SCHK;
      end
      bba_pkg::S_SCHK: begin
        if (mem_rdata) begin
          state_nxt = bba_pkg::S_ACLR;
        end else begin
          node_nxt  = node_r + 1'b1;
          state_nxt = bba_pkg::S_SRD;
        end
      end
      bba_pkg::S_ACLR: begin
        seq_we    = 1'b1;
        seq_wdata = 1'b0;
        seq_waddr = node_r;
        cnt_op    = bba_pkg::CNT_DEC;
        state_nxt = bba_pkg::S_SPLIT;
      end
      // split down, freeing each upper half
      bba_pkg::S_SPLIT: begin
        if (lvl_r < tgt_r) begin
          node_nxt  = node_r << 1;
          seq_we    = 1'b1;
          seq_wdata = 1'b1;
          seq_waddr = (node_r << 1) | TL'(1);
          cnt_op    = bba_pkg::CNT_INC;
          cnt_lvl   = lvl_up;
          lvl_nxt   = lvl_up;
        end else begin
          res_addr_nxt = ADDR_BITS'(node_r ^ (TL'(1) << tgt_r)) << ord_r;
          res_ord_nxt  = ord_r;
          res_stat_nxt = bba_pkg::ST_OK;
          state_nxt    = bba_pkg::S_RESP;
        end
      end
      // walk up: freed block or any ancestor already free is rejected
      bba_pkg::S_WRD: begin
        seq_raddr = walk_r;
        state_nxt = bba_pkg::S_WCHK;
      end
      bba_pkg::S_WCHK: begin
        if (mem_rdata) begin
          state_nxt = bba_pkg::S_RESP;
        end else if (walk_r == TL'(1)) begin
          lvl_nxt   = tgt_r;
          state_nxt = bba_pkg::S_MRD;
        end else begin
          walk_nxt  = walk_r >> 1;
          state_nxt = bba_pkg::S_WRD;
        end
      end
      // merge with free buddies
      bba_pkg::S_MRD: begin
        seq_raddr = node_r ^ TL'(1);
        state_nxt = (lvl_r == '0) ? bba_pkg::S_MSET : bba_pkg::S_MCHK;
      end
      bba_pkg::S_MCHK: begin
        if (mem_rdata) begin
          seq_we    = 1'b1;
          seq_wdata = 1'b0;
          seq_waddr = node_r ^ TL'(1);
          cnt_op    = bba_pkg::CNT_DEC;
          node_nxt  = node_r >> 1;
          lvl_nxt   = lvl_r - 1'b1;
          state_nxt = bba_pkg::S_MRD;
        end else begin
          state_nxt = bba_pkg::S_MSET;
        end
      end
      bba_pkg::S_MSET: begin
        seq_we       = 1'b1;
        seq_wdata    = 1'b1;
        seq_waddr    = node_r;
        cnt_op       = bba_pkg::CNT_INC;
        res_addr_nxt = '0;
        res_ord_nxt  = ord_r;
        res_stat_nxt = bba_pkg::ST_OK;
        state_nxt    = bba_pkg::S_RESP;
      end
      bba_pkg::S_RESP: begin
        if (out_free) state_nxt = bba_pkg::S_IDLE;
      end
      default: state_nxt = bba_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bba_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    lvl_r      <= lvl_nxt;
    node_r     <= node_nxt;
    walk_r     <= walk_nxt;
    res_addr_r <= res_addr_nxt;
    res_ord_r  <= res_ord_nxt;
    res_stat_r <= res_stat_nxt;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == bba_pkg::S_RESP && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
    if (state_r == bba_pkg::S_RESP && out_free) begin
      out_tdata_r <= OUT_W'({res_stat_r, res_ord_r, res_addr_r});
    end
  end

`ifndef SYNTH
  a_no_take_while_clearing : assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> clr_mask_r == 2'b00)
    else $error("item taken during clearing pass");

  a_scan_level_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bba_pkg::S_SRD) |-> (cnt_r[pool_r][lvl_r] != '0))
    else $error("scanning a level with no free node");

  a_resp_emits : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bba_pkg::S_RESP) && out_free |=> out_tvalid_r)
    else $error("result not presented");
`endif

endmodule
`default_nettype wire

/* tb/sv/buddy_block_allocator_unit_tb.sv */
// Testbench for buddy_block_allocator_unit: streams allocate/free requests into both
// pools and checks every result against a buddy-tree predictor kept in the bench.
// Depends on bba_pkg and the allocator RTL only.
`default_nettype none
module buddy_block_allocator_unit_tb;

  localparam int  LEVELS     = bba_pkg::TREE_LEVELS_DEF;
  localparam int  ABITS      = bba_pkg::ADDR_BITS_DEF;
  localparam int  NODES      = 1 << LEVELS;
  localparam int  IN_W       = ((2*ABITS+1+7)/8)*8;
  localparam int  OUT_W      = ((ABITS+bba_pkg::ORD_W+2+7)/8)*8;
  localparam int  CYCLE_CAP  = 20000000;
  localparam int  HOLD_LEN   = 3000;
  localparam int  NPHASE     = 6;

  typedef struct packed {
    logic        kind;
    logic        pool;
    logic [40:0] size;
    logic [39:0] offset;
  } request_t;

  // status in the top bits, address in the low bits, as on out_tdata
  typedef struct packed {
    logic [1:0]                status;
    logic [bba_pkg::ORD_W-1:0] order;
    logic [39:0]               addr;
  } grant_t;

  typedef struct {
    logic        pool;
    logic [39:0] addr;
    int          order;
  } held_block_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;   // request_size, block_offset, zero pad
  logic [1:0] in_tuser = '0;        // req_type, pool_select
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;      // block_address, block_order, status, zero pad
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [bba_pkg::ORD_W-1:0] cfg_wdata = '0;

  buddy_block_allocator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Predictor state: free bit per tree node, per pool, plus order registers
  bit         node_free[2][NODES];
  logic [5:0] min_ord_reg[2];
  logic [5:0] max_ord_reg[2];

  request_t    pending_reqs[$];
  grant_t      expected_grants[$];
  held_block_t held_blocks[$];

  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  int hold_cnt = 0;
  longint cycles = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic void clear_pool(input int p);
    for (int i = 0; i < NODES; i++) node_free[p][i] = 0;
    node_free[p][1] = 1;
  endfunction

  // Effective orders of a pool after clamping
  function automatic void pool_orders(input int p, output int mx, output int mn);
    mx = max_ord_reg[p];
    mn = min_ord_reg[p];
    if (mx > ABITS) mx = ABITS;
    if (mn > mx) mn = mx;
    if (mx - mn > LEVELS - 1) mn = mx - (LEVELS - 1);
  endfunction

  // Work out one result and update the tree
  function automatic grant_t allocate_or_free(input request_t r);
    grant_t g;
    int mx, mn, ord, tgt, lvl, node;
    bit found;
    longint unsigned sz, off;
    g = '{addr: '0, order: '0, status: bba_pkg::ST_OVERSIZE};
    pool_orders(r.pool, mx, mn);
    sz = r.size;
    off = r.offset;
    ord = 0;
    while (ord < 63 && (64'd1 << ord) < sz) ord++;
    if (ord < mn) ord = mn;
    if (ord > mx) return g;
    tgt = mx - ord;
    if (r.kind == bba_pkg::REQ_ALLOC) begin
      found = 0;
      node = 0;
      for (lvl = tgt; lvl >= 0 && !found; lvl--) begin
        for (int i = 1 << lvl; i < (2 << lvl); i++) begin
          if (node_free[r.pool][i]) begin
            node = i;
            found = 1;
            break;
          end
        end
      end
      if (!found) begin
        g.status = bba_pkg::ST_NOMEM;
        return g;
      end
      lvl = $clog2(node + 1) - 1;
      node_free[r.pool][node] = 0;
      while (lvl < tgt) begin
        node = node << 1;
        lvl++;
        node_free[r.pool][node | 1] = 1;
      end
      g.addr = 40'((longint'(node - (1 << tgt))) << ord);
      g.order = bba_pkg::ORD_W'(ord);
      g.status = bba_pkg::ST_OK;
      return g;
    end
    // free: reject outside, misaligned, or already free blocks
    if ((off >> mx) != 0) return g;
    if ((off & ((64'd1 << ord) - 1)) != 0) return g;
    node = (1 << tgt) + int'(off >> ord);
    for (int i = node; i != 0; i = i >> 1)
      if (node_free[r.pool][i]) return g;
    lvl = tgt;
    while (lvl > 0 && node_free[r.pool][node ^ 1]) begin
      node_free[r.pool][node ^ 1] = 0;
      node = node >> 1;
      lvl--;
    end
    node_free[r.pool][node] = 1;
    g.order = bba_pkg::ORD_W'(ord);
    g.status = bba_pkg::ST_OK;
    return g;
  endfunction

  // Queue one request with its expected result; remember granted blocks
  task automatic add_req(input logic kind, input logic pool, input logic [40:0] size,
                         input logic [39:0] offset);
    request_t r;
    grant_t g;
    r = '{kind: kind, pool: pool, size: size, offset: offset};
    g = allocate_or_free(r);
    if (kind == bba_pkg::REQ_ALLOC && g.status == bba_pkg::ST_OK)
      held_blocks.insert(held_blocks.size(),
                         held_block_t'{pool: pool, addr: g.addr, order: int'(g.order)});
    pending_reqs.insert(pending_reqs.size(), r);
    expected_grants.insert(expected_grants.size(), g);
  endtask

  // A size whose rounded order is exactly ord (before the pool minimum)
  function automatic logic [40:0] size_of_order(input int ord);
    longint unsigned half;
    if (ord == 0) return 41'd1;
    half = 64'd1 << (ord - 1);
    return 41'((64'd1 << ord) - ({$urandom, $urandom} % half));
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      bba_pkg::REG_DEV_MIN:  begin min_ord_reg[0] = val; clear_pool(0); end
      bba_pkg::REG_DEV_MAX:  begin max_ord_reg[0] = val; clear_pool(0); end
      bba_pkg::REG_HOST_MIN: begin min_ord_reg[1] = val; clear_pool(1); end
      default:               begin max_ord_reg[1] = val; clear_pool(1); end
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_grants.size() != 0 || in_tvalid)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_reqs(input int count);
    int r, p, mx, mn, ord, k;
    logic [40:0] sz;
    held_block_t b;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      p = $urandom_range(1);
      pool_orders(p, mx, mn);
      if (r >= 45 && r < 85 && held_blocks.size() != 0) begin
        // return a block we own, size picked to round to its order
        k = $urandom_range(held_blocks.size() - 1);
        b = held_blocks[k];
        held_blocks.delete(k);
        add_req(bba_pkg::REQ_FREE, b.pool, size_of_order(b.order), b.addr);
      end else if (r >= 85 && r < 93) begin
        // noise free: arbitrary offset and size
        sz = 41'({$urandom, $urandom});
        if (sz == 0) sz = 1;
        add_req(bba_pkg::REQ_FREE, 1'(p),
                ($urandom_range(1)) ? sz : size_of_order($urandom_range(mx)),
                40'({$urandom, $urandom}));
      end else if (r >= 93) begin
        sz = 41'({$urandom, $urandom});
        if (sz == 0) sz = 1;
        add_req(bba_pkg::REQ_ALLOC, 1'(p), sz, 40'({$urandom, $urandom}));
      end else begin
        // mostly small blocks so the pool keeps many live allocations
        if ($urandom_range(3) == 0) ord = $urandom_range(mx);
        else ord = mn + $urandom_range(2);
        if (ord > mx) ord = mx;
        add_req(bba_pkg::REQ_ALLOC, 1'(p), size_of_order(ord), 40'({$urandom, $urandom}));
      end
    end
  endtask

  // Reset, then phases of register settings and idling modes
  initial begin
    logic [5:0] settings [NPHASE][4];
    int idle_tab [NPHASE];
    int stall_tab [NPHASE];
    settings = '{'{6, 16, 6, 16}, '{0, 10, 3, 12}, '{0, 0, 40, 40},
                 '{63, 63, 0, 40}, '{2, 12, 6, 16}, '{6, 16, 0, 5}};
    idle_tab  = '{0, 87, 0, 24, 0, 0};
    stall_tab = '{0, 0, 87, 24, 0, 87};
    min_ord_reg = '{bba_pkg::MIN_ORDER_RST, bba_pkg::MIN_ORDER_RST};
    max_ord_reg = '{bba_pkg::MAX_ORDER_RST, bba_pkg::MAX_ORDER_RST};
    clear_pool(0);
    clear_pool(1);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: edges, errors, merges, both pools
    add_req(bba_pkg::REQ_ALLOC, 1'b0, 41'd1, '0);
    add_req(bba_pkg::REQ_FREE,  1'b0, 41'd1, '0);
    add_req(bba_pkg::REQ_FREE,  1'b0, 41'd65536, '0);
    add_req(bba_pkg::REQ_ALLOC, 1'b0, 41'd65536, '1);
    add_req(bba_pkg::REQ_ALLOC, 1'b0, 41'd64, '0);
    add_req(bba_pkg::REQ_FREE,  1'b0, 41'd65536, '0);
    add_req(bba_pkg::REQ_ALLOC, 1'b0, 41'd65537, '0);
    add_req(bba_pkg::REQ_ALLOC, 1'b0, 41'd1099511627776, '0);
    add_req(bba_pkg::REQ_ALLOC, 1'b1, 41'h1ff_ffff_ffff, '0);
    add_req(bba_pkg::REQ_ALLOC, 1'b0, 41'd0, '0);
    add_req(bba_pkg::REQ_FREE,  1'b0, 41'd64, 40'd65536);
    add_req(bba_pkg::REQ_FREE,  1'b0, 41'd128, 40'd32);
    add_req(bba_pkg::REQ_FREE,  1'b1, 41'd1, '1);
    add_req(bba_pkg::REQ_ALLOC, 1'b1, 41'd100, '0);
    add_req(bba_pkg::REQ_ALLOC, 1'b1, 41'd64, '0);
    add_req(bba_pkg::REQ_ALLOC, 1'b1, 41'd200, '0);
    add_req(bba_pkg::REQ_FREE,  1'b1, 41'd64, 40'd128);
    add_req(bba_pkg::REQ_FREE,  1'b1, 41'd64, 40'd128);
    add_req(bba_pkg::REQ_FREE,  1'b1, 41'd128, 40'd0);
    add_req(bba_pkg::REQ_FREE,  1'b1, 41'd256, 40'd256);
    add_req(bba_pkg::REQ_ALLOC, 1'b1, 41'd32768, '0);
    held_blocks.delete();

    for (int ph = 0; ph < NPHASE; ph++) begin
      wait_drained();
      if (ph != 0) begin
        held_blocks.delete();
        for (int i = 0; i < 4; i++) write_reg(2'(i), settings[ph][i]);
      end
      send_idle_pct = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      if (ph == 4) hold_req <= 1'b1;
      random_reqs(190);
    end
    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Driver: offer queued requests with random idle cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= IN_W'({pending_reqs[0].offset, pending_reqs[0].size});
        in_tuser <= {pending_reqs[0].pool, pending_reqs[0].kind};
        void'(pending_reqs.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, once
  always @(posedge clk) begin
    if (hold_req && !hold_seen) begin
      hold_cnt <= HOLD_LEN;
      hold_seen <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Monitor: compare each result item with the oldest expectation
  always @(posedge clk) begin
    grant_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = grant_t'(out_tdata[ABITS+bba_pkg::ORD_W+1:0]);
      if (expected_grants.size() == 0) begin
        report("unexpected result item", got.addr, 0);
      end else begin
        want = expected_grants.pop_front();
        if (got.addr !== want.addr) report("block_address", got.addr, want.addr);
        if (got.order !== want.order) report("block_order", got.order, want.order);
        if (got.status !== want.status) report("status", got.status, want.status);
      end
    end
    out_tready <= rst_n && hold_cnt == 0 && $urandom_range(99) >= recv_stall_pct;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
`default_nettype wire

/* files.f */
design/bba_pkg.sv
design/bba_ram.sv
design/buddy_block_allocator_unit.sv
tb/sv/buddy_block_allocator_unit_tb.sv
